FILE: rtl/core/fwna_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fwna_pkg: shared types and constants
// Mode codes, character codes, digit limits and the controller/datapath
// command and status bundles of the number-to-ASCII converter.
// ---------------------------------------------------------------------------
package fwna_pkg;

    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } op_t;

    localparam int OP_W    = 2;
    localparam int IN_W    = 32;  // width of the value field
    localparam int COUNT_W = 6;
    localparam int IDX_W   = 5;
    localparam int CHAR_W  = 7;
    localparam int EXT_W   = 64;  // width of the zero-extended magnitude used for digit selection

    localparam int DEC_DIGITS = 10;

    localparam logic [COUNT_W-1:0] MAX_DEC = 6'd10;
    localparam logic [COUNT_W-1:0] MAX_HEX = 6'd8;
    localparam logic [COUNT_W-1:0] MAX_BIN = 6'd32;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_sign;
        logic emit_digit;
    } fwna_cmd_t;

    typedef struct packed {
        logic is_dec;
        logic is_signed;
        logic count_zero;
        logic bits_last;
        logic digit_last;
        logic out_free;
    } fwna_status_t;

endpackage

FILE: rtl/core/fwna_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fwna_if: stream channels
// Input channel (mode, value, digit count) and output channel (character,
// column offset, last marker), each with valid/ready.
// ---------------------------------------------------------------------------
interface fwna_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] value;
    logic [5:0]  digit_count;

    modport source (output valid, output op, output value, output digit_count,
                    input ready);
    modport sink   (input valid, input op, input value, input digit_count,
                    output ready);
endinterface

interface fwna_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic [5:0] position;
    logic       last;

    modport source (output valid, output char_code, output position, output last,
                    input ready);
    modport sink   (input valid, input char_code, input position, input last,
                    output ready);
endinterface

FILE: rtl/core/fwna_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fwna_ctrl: conversion sequencer
// Takes one number at a time, runs the decimal conversion (decimal modes only),
// then steps the sign (signed decimal only) and the digits into the output register.
// ---------------------------------------------------------------------------
module fwna_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output fwna_pkg::fwna_cmd_t    cmd,
    input  fwna_pkg::fwna_status_t status
);
    import fwna_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_SIGN  = 4'b0100,
        S_DIGIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_conv;

    assign in_ready   = (state_reg == S_IDLE);
    assign after_conv = status.count_zero ? S_IDLE : S_DIGIT;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (!status.is_dec)
                begin
                    state_next = after_conv;
                end
                else
                begin
                    cmd.shift = 1'b1;
                    if (status.bits_last)
                    begin
                        state_next = status.is_signed ? S_SIGN : after_conv;
                    end
                end
            end
            S_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = after_conv;
                end
            end
            S_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.digit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/fwna_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fwna_dp: conversion datapath
// Magnitude and BCD shift-add-3 registers, digit index and column counters,
// digit selection and the output character register.
// ---------------------------------------------------------------------------
module fwna_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fwna_pkg::fwna_cmd_t            cmd,
    output fwna_pkg::fwna_status_t         status,
    input  logic [fwna_pkg::OP_W-1:0]     op,
    input  logic [fwna_pkg::IN_W-1:0]     value,
    input  logic [fwna_pkg::COUNT_W-1:0]  digit_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fwna_pkg::CHAR_W-1:0]   char_code,
    output logic [fwna_pkg::COUNT_W-1:0]  position,
    output logic                          last
);
    import fwna_pkg::*;

    localparam int BCNT_W = $clog2(VALUE_WIDTH + 1);

    op_t                         op_reg;
    logic [COUNT_W-1:0]          count_reg;
    logic                        neg_reg;
    logic [VALUE_WIDTH-1:0]      mag_reg;
    logic [DEC_DIGITS-1:0][3:0]  bcd_reg;
    logic [BCNT_W-1:0]           bit_cnt_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [COUNT_W-1:0]          pos_reg;
    logic                        valid_reg;
    logic [CHAR_W-1:0]           char_reg;
    logic [COUNT_W-1:0]          position_reg;
    logic                        last_reg;

    op_t                         op_in;
    logic [VALUE_WIDTH-1:0]      v_in;
    logic                        neg_in;
    logic [COUNT_W-1:0]          max_in;
    logic [COUNT_W-1:0]          count_sat;
    logic [DEC_DIGITS-1:0][3:0]  bcd_adj;
    logic [EXT_W-1:0]            mag_ext;
    logic [3:0]                  digit;
    logic [CHAR_W-1:0]           digit_char;

    always_comb
    begin
        op_in  = op_t'(op);
        v_in   = VALUE_WIDTH'(value);
        neg_in = (op_in == OP_SDEC) && v_in[VALUE_WIDTH-1];
        case (op_in)
            OP_HEX:  max_in = MAX_HEX;
            OP_BIN:  max_in = MAX_BIN;
            default: max_in = MAX_DEC;
        endcase
        count_sat = (digit_count > max_in) ? max_in : digit_count;
    end

    // add 3 to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int k = 0; k < DEC_DIGITS; k++)
        begin
            bcd_adj[k] = (bcd_reg[k] >= 4'd5) ? bcd_reg[k] + 4'd3 : bcd_reg[k];
        end
    end

    always_comb
    begin
        mag_ext = EXT_W'(mag_reg);
        case (op_reg)
            OP_HEX:  digit = mag_ext[{1'b0, idx_reg[2:0], 2'b00} +: 4];
            OP_BIN:  digit = {3'b000, mag_ext[{1'b0, idx_reg}]};
            default: digit = bcd_reg[idx_reg[3:0]];
        endcase
        digit_char = (digit < 4'd10) ? CH_ZERO + CHAR_W'(digit)
                                     : CH_A + CHAR_W'(digit - 4'd10);
    end

    assign status.is_dec     = (op_reg == OP_UDEC) || (op_reg == OP_SDEC);
    assign status.is_signed  = (op_reg == OP_SDEC);
    assign status.count_zero = (count_reg == '0);
    assign status.bits_last  = (bit_cnt_reg == BCNT_W'(1));
    assign status.digit_last = (idx_reg == '0);
    assign status.out_free   = !valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_in;
            count_reg   <= count_sat;
            neg_reg     <= neg_in;
            mag_reg     <= neg_in ? (~v_in + VALUE_WIDTH'(1)) : v_in;
            bcd_reg     <= '0;
            bit_cnt_reg <= BCNT_W'(VALUE_WIDTH);
            idx_reg     <= IDX_W'(count_sat - COUNT_W'(1));
            pos_reg     <= (op_in == OP_SDEC) ? COUNT_W'(1) : '0;
        end
        else if (cmd.shift)
        begin
            // drop the carry out of the top digit: only the low digits are kept
            bcd_reg     <= {bcd_adj[DEC_DIGITS-1][2:0], bcd_adj[DEC_DIGITS-2:0],
                            mag_reg[VALUE_WIDTH-1]};
            mag_reg     <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - BCNT_W'(1);
        end
        else if (cmd.emit_digit)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
            pos_reg <= pos_reg + COUNT_W'(1);
        end

        if (cmd.emit_sign)
        begin
            char_reg     <= neg_reg ? CH_MINUS : CH_PLUS;
            position_reg <= '0;
            last_reg     <= (count_reg == '0);
        end
        else if (cmd.emit_digit)
        begin
            char_reg     <= digit_char;
            position_reg <= pos_reg;
            last_reg     <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            // drop the character once its transfer completes
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign char_code = char_reg;
    assign position  = position_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/core/fixed_width_number_to_ascii_core.sv
`timescale 1ns / 1ps
// Sequence: after acceptance the value is loaded, converted (decimal only: one BCD
// shift-add-3 step per bit), then the sign and the digits are registered for output.
// Input: a new number is taken only while the sequencer is idle, so not before the
// previous one is fully issued; characters leave at one per cycle while taken.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
// fixed_width_number_to_ascii_core: number to fixed-width ASCII digits
// Emits the sign (signed decimal) and the low digit_count digits of a value,
// most significant first, with column offset and last marker.
// ---------------------------------------------------------------------------
module fixed_width_number_to_ascii_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    fwna_in_if.sink    in_ch,
    fwna_out_if.source out_ch
);
    import fwna_pkg::*;

    fwna_cmd_t    cmd;
    fwna_status_t status;

    fwna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .status   (status)
    );

    fwna_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (in_ch.op),
        .value       (in_ch.value),
        .digit_count (in_ch.digit_count),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .char_code   (out_ch.char_code),
        .position    (out_ch.position),
        .last        (out_ch.last)
    );

endmodule

FILE: sim/tb_fixed_width_number_to_ascii_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fixed_width_number_to_ascii_core: number-to-ASCII converter testbench
// A directed set of edge cases, then random numbers in all four modes, go
// through a queue-fed driver. Each accepted number is spelled out here into
// the characters it should produce, and a monitor checks every character
// transfer in order. Both sides stall at random, and one long output hold
// backs the block up into its input.
// ---------------------------------------------------------------------------
module tb_fixed_width_number_to_ascii_core;
    import fwna_pkg::*;

    localparam int RANDOM_NUMBERS = 380;
    localparam int IDLE_PCT       = 38;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        op_t                mode;
        logic [IN_W-1:0]    value;
        logic [COUNT_W-1:0] digit_count;
    } number_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic [COUNT_W-1:0] position;
        logic               last;
    } char_t;

    logic clk = 1'b0;
    logic rst_n;

    fwna_in_if  num_if ();
    fwna_out_if chr_if ();

    number_t pending_numbers[$];
    char_t   expected_chars[$];

    int numbers_queued   = 0;
    int numbers_accepted = 0;
    int chars_checked    = 0;
    int char_errors      = 0;
    int mode_seen[4]     = '{0, 0, 0, 0};
    int hold_left        = 0;
    bit hold_done        = 1'b0;

    always #1 clk = ~clk;

    fixed_width_number_to_ascii_core #(
        .VALUE_WIDTH(IN_W)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (num_if),
        .out_ch (chr_if)
    );

    // Calm stretch with no stalls on either side
    function automatic bit steady();
        return numbers_accepted >= 150 && numbers_accepted < 230;
    endfunction

    // Append the characters one number should produce
    function automatic void spell_number(op_t mode, logic [IN_W-1:0] value,
                                         logic [COUNT_W-1:0] count_in);
        logic [63:0] mag;
        logic [63:0] weight;
        int          radix;
        int          max_digits;
        int          digits;
        int          pos0;
        int          d;
        char_t       c;

        mag  = {32'b0, value};
        pos0 = 0;
        case (mode)
            OP_HEX:  begin radix = 16; max_digits = int'(MAX_HEX); end
            OP_BIN:  begin radix = 2;  max_digits = int'(MAX_BIN); end
            default: begin radix = 10; max_digits = int'(MAX_DEC); end
        endcase
        digits = (int'(count_in) > max_digits) ? max_digits : int'(count_in);

        if (mode == OP_SDEC)
        begin
            // Negating the most negative value wraps to 2^31, which is the magnitude
            if (value[IN_W-1])
                mag = {32'b0, -value};
            c.char_code = value[IN_W-1] ? CH_MINUS : CH_PLUS;
            c.position  = '0;
            c.last      = (digits == 0);
            expected_chars.push_back(c);
            pos0 = 1;
        end

        for (int k = 0; k < digits; k++)
        begin
            weight = 64'd1;
            for (int j = 0; j < digits - 1 - k; j++)
                weight = weight * radix;
            d = int'((mag / weight) % radix);
            c.char_code = (d < 10) ? CHAR_W'(CH_ZERO + d) : CHAR_W'(CH_A + d - 10);
            c.position  = COUNT_W'(pos0 + k);
            c.last      = (k == digits - 1);
            expected_chars.push_back(c);
        end
    endfunction

    task automatic add_number(op_t mode, logic [IN_W-1:0] value,
                              logic [COUNT_W-1:0] digit_count);
        number_t n;

        n.mode        = mode;
        n.value       = value;
        n.digit_count = digit_count;
        pending_numbers.push_back(n);
        numbers_queued++;
    endtask

    task automatic report_error(string what);
        char_errors++;
        if (char_errors <= 10)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Driver: record each accepted number, then offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        number_t n;

        if (!rst_n)
        begin
            num_if.valid       <= 1'b0;
            num_if.op          <= '0;
            num_if.value       <= '0;
            num_if.digit_count <= '0;
        end
        else
        begin
            if (num_if.valid && num_if.ready)
            begin
                spell_number(op_t'(num_if.op), num_if.value, num_if.digit_count);
                mode_seen[num_if.op]++;
                numbers_accepted++;
            end
            if (!num_if.valid || num_if.ready)
            begin
                if (pending_numbers.size() > 0 &&
                    (steady() || $urandom_range(99) >= IDLE_PCT))
                begin
                    n = pending_numbers.pop_front();
                    num_if.valid       <= 1'b1;
                    num_if.op          <= n.mode;
                    num_if.value       <= n.value;
                    num_if.digit_count <= n.digit_count;
                end
                else
                    num_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each character transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        char_t e;

        if (!rst_n)
            chr_if.ready <= 1'b0;
        else
        begin
            if (chr_if.valid && chr_if.ready)
            begin
                chars_checked++;
                if (expected_chars.size() == 0)
                    report_error($sformatf("unexpected char 0x%02h pos %0d last %0b",
                                           chr_if.char_code, chr_if.position,
                                           chr_if.last));
                else
                begin
                    e = expected_chars.pop_front();
                    if (chr_if.char_code !== e.char_code)
                        report_error($sformatf("char_code exp 0x%02h got 0x%02h",
                                               e.char_code, chr_if.char_code));
                    if (chr_if.position !== e.position)
                        report_error($sformatf("position exp %0d got %0d",
                                               e.position, chr_if.position));
                    if (chr_if.last !== e.last)
                        report_error($sformatf("last exp %0b got %0b (pos %0d)",
                                               e.last, chr_if.last, e.position));
                end
            end

            // Hold off once for a long stretch so the input backs up
            if (!hold_done && numbers_accepted >= 60)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chr_if.ready <= 1'b0;
            end
            else
                chr_if.ready <= steady() || $urandom_range(99) >= IDLE_PCT;
        end
    end

    initial
    begin : stimulus
        op_t                mode;
        logic [IN_W-1:0]    value;
        logic [COUNT_W-1:0] count;
        int                 max_digits;

        num_if.valid       = 1'b0;
        num_if.op          = '0;
        num_if.value       = '0;
        num_if.digit_count = '0;
        chr_if.ready       = 1'b0;
        rst_n              = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, saturation, zero counts and the most negative value
        add_number(OP_UDEC, 32'd0,         6'd0);
        add_number(OP_UDEC, 32'hFFFF_FFFF, 6'd10);
        add_number(OP_UDEC, 32'hFFFF_FFFF, 6'd63);
        add_number(OP_UDEC, 32'd1234567,   6'd1);
        add_number(OP_UDEC, 32'd0,         6'd10);
        add_number(OP_SDEC, 32'd0,         6'd10);
        add_number(OP_SDEC, 32'h8000_0000, 6'd10);
        add_number(OP_SDEC, 32'h8000_0000, 6'd63);
        add_number(OP_SDEC, 32'h7FFF_FFFF, 6'd10);
        add_number(OP_SDEC, 32'hFFFF_FFFF, 6'd3);
        add_number(OP_SDEC, 32'hFFFF_FF85, 6'd0);
        add_number(OP_SDEC, 32'd42,        6'd0);
        add_number(OP_HEX,  32'hDEAD_BEEF, 6'd8);
        add_number(OP_HEX,  32'h0123_ABCF, 6'd63);
        add_number(OP_HEX,  32'h89AB_CDEF, 6'd5);
        add_number(OP_HEX,  32'h0000_0000, 6'd0);
        add_number(OP_HEX,  32'hFFFF_FFFF, 6'd9);
        add_number(OP_BIN,  32'hA5A5_A5A5, 6'd32);
        add_number(OP_BIN,  32'hFFFF_FFFF, 6'd63);
        add_number(OP_BIN,  32'h0000_0000, 6'd0);
        add_number(OP_BIN,  32'h8000_0001, 6'd1);
        add_number(OP_BIN,  32'h8000_0000, 6'd32);
        add_number(OP_BIN,  32'h5A5A_5A5A, 6'd33);

        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            mode = op_t'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0:       value = $urandom_range(0, 99);
                1:       value = 32'hFFFF_FFFF - $urandom_range(0, 99);
                2:       value = 32'h8000_0000 ^ $urandom_range(0, 3);
                3:       value = 32'd1 << $urandom_range(0, 31);
                default: value = $urandom;
            endcase
            case (mode)
                OP_HEX:  max_digits = int'(MAX_HEX);
                OP_BIN:  max_digits = int'(MAX_BIN);
                default: max_digits = int'(MAX_DEC);
            endcase
            // Mostly in-range counts, sometimes anything the field holds
            if ($urandom_range(9) == 0)
                count = COUNT_W'($urandom_range(0, 63));
            else
                count = COUNT_W'($urandom_range(0, max_digits));
            add_number(mode, value, count);
        end

        wait (numbers_accepted == numbers_queued);
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers (udec %0d, sdec %0d, hex %0d, bin %0d),",
                 numbers_accepted, mode_seen[OP_UDEC], mode_seen[OP_SDEC],
                 mode_seen[OP_HEX], mode_seen[OP_BIN]);
        $display("checked %0d characters with random stalls and one long output hold.",
                 chars_checked);
        if (char_errors == 0 && expected_chars.size() == 0)
            $display("fixed_width_number_to_ascii_core test passed");
        else
        begin
            $display("%0d mismatches, %0d characters missing",
                     char_errors, expected_chars.size());
            $display("fixed_width_number_to_ascii_core test failed");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout: %0d of %0d numbers accepted, %0d characters outstanding",
                 numbers_accepted, numbers_queued, expected_chars.size());
        $display("fixed_width_number_to_ascii_core test failed");
        $finish;
    end

endmodule
